// File: rtl/tksd_pkg.sv
// Shared types and constants for the terminal key sequence decoder.
package tksd_pkg;

    // One input beat: a received byte or a read timeout.
    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } item_t;

    // One result beat: a plain byte key or a named key code.
    typedef struct packed {
        logic       special;
        logic [7:0] key;
    } key_beat_t;

    // Decoder result handed to the result register.
    typedef struct packed {
        logic      emit;
        key_beat_t beat;
    } dec_result_t;

    // Width of a named key code.
    localparam int KeyCodeW = 4;

    // Named key lookup result.
    typedef struct packed {
        logic                hit;
        logic [KeyCodeW-1:0] code;
    } named_t;

    // Parser state.
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_CSI    = 3'd2,
        MODE_SS3    = 3'd3,
        MODE_SKIP   = 3'd4,
        MODE_DIGIT  = 3'd5,
        MODE_MOD    = 3'd6,
        MODE_LETTER = 3'd7
    } mode_t;

    // Input opcodes.
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    // Bytes with a meaning in a sequence.
    localparam logic [7:0] CHAR_ESC   = 8'h1B;
    localparam logic [7:0] CHAR_B     = 8'h62;
    localparam logic [7:0] CHAR_F     = 8'h66;
    localparam logic [7:0] CHAR_LBRK  = 8'h5B;
    localparam logic [7:0] CHAR_O     = 8'h4F;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_3     = 8'h33;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UB    = 8'h42;
    localparam logic [7:0] CHAR_UC    = 8'h43;
    localparam logic [7:0] CHAR_UD    = 8'h44;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_UH    = 8'h48;

    // Named key codes.
    localparam logic [KeyCodeW-1:0] KEY_LEFT   = 4'd0;
    localparam logic [KeyCodeW-1:0] KEY_RIGHT  = 4'd1;
    localparam logic [KeyCodeW-1:0] KEY_UP     = 4'd2;
    localparam logic [KeyCodeW-1:0] KEY_DOWN   = 4'd3;
    localparam logic [KeyCodeW-1:0] KEY_DEL    = 4'd4;
    localparam logic [KeyCodeW-1:0] KEY_HOME   = 4'd5;
    localparam logic [KeyCodeW-1:0] KEY_END    = 4'd6;
    localparam logic [KeyCodeW-1:0] KEY_PGUP   = 4'd7;
    localparam logic [KeyCodeW-1:0] KEY_PGDN   = 4'd8;
    localparam logic [KeyCodeW-1:0] KEY_WLEFT  = 4'd9;
    localparam logic [KeyCodeW-1:0] KEY_WRIGHT = 4'd10;

endpackage

// File: rtl/tksd_in_stage.sv
// Input register stage that holds one accepted beat for the decoder.
module tksd_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  tksd_pkg::item_t item,
    input  logic           advance,
    output logic           stage_valid,
    output tksd_pkg::item_t stage_item
);

    logic            vld_reg;
    logic            vld_next;
    tksd_pkg::item_t data_reg;

    // The stage takes a new beat when empty or when its beat moves on.
    assign item_ready = !vld_reg || advance;

    always_comb
    begin
        vld_next = vld_reg;
        if (item_ready)
        begin
            vld_next = item_valid;
        end
    end

    // Control register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            data_reg <= item;
        end
    end

    assign stage_valid = vld_reg;
    assign stage_item  = data_reg;

endmodule

// File: rtl/tksd_decode.sv
// Escape sequence parser: state registers and per-beat key decode.
module tksd_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  tksd_pkg::item_t       item,
    output tksd_pkg::dec_result_t result
);

    tksd_pkg::mode_t mode_reg;
    tksd_pkg::mode_t mode_next;
    logic [3:0]      digit_reg;
    logic [3:0]      digit_next;
    logic            alt_reg;
    logic            alt_next;

    logic            is_byte;
    logic [7:0]      b;
    logic            is_digit;
    tksd_pkg::named_t named;
    logic            emit;

    // Final letter of a CSI sequence.
    function automatic tksd_pkg::named_t letter_key(input logic [7:0] c, input logic alt);
        tksd_pkg::named_t r;
        r.hit  = 1'b1;
        r.code = tksd_pkg::KEY_UP;
        case (c)
            tksd_pkg::CHAR_UA: r.code = tksd_pkg::KEY_UP;
            tksd_pkg::CHAR_UB: r.code = tksd_pkg::KEY_DOWN;
            tksd_pkg::CHAR_UC: r.code = alt ? tksd_pkg::KEY_WRIGHT : tksd_pkg::KEY_RIGHT;
            tksd_pkg::CHAR_UD: r.code = alt ? tksd_pkg::KEY_WLEFT : tksd_pkg::KEY_LEFT;
            tksd_pkg::CHAR_UH: r.code = tksd_pkg::KEY_HOME;
            tksd_pkg::CHAR_UF: r.code = tksd_pkg::KEY_END;
            default:           r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    // Key for a digit followed by a tilde; the digit is held as its low nibble.
    function automatic tksd_pkg::named_t tilde_key(input logic [3:0] d);
        tksd_pkg::named_t r;
        r.hit  = 1'b1;
        r.code = tksd_pkg::KEY_HOME;
        case (d)
            4'd1:    r.code = tksd_pkg::KEY_HOME;
            4'd3:    r.code = tksd_pkg::KEY_DEL;
            4'd4:    r.code = tksd_pkg::KEY_END;
            4'd5:    r.code = tksd_pkg::KEY_PGUP;
            4'd6:    r.code = tksd_pkg::KEY_PGDN;
            4'd7:    r.code = tksd_pkg::KEY_HOME;
            4'd8:    r.code = tksd_pkg::KEY_END;
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    assign is_byte  = (item.opcode == tksd_pkg::OP_BYTE);
    assign b        = item.rx_byte;
    assign is_digit = (b >= tksd_pkg::CHAR_0) && (b <= tksd_pkg::CHAR_9);

    // Next state of the parser.
    always_comb
    begin
        mode_next  = tksd_pkg::MODE_IDLE;
        digit_next = digit_reg;
        alt_next   = alt_reg;
        case (mode_reg)
            tksd_pkg::MODE_IDLE:
            begin
                if (is_byte && (b == tksd_pkg::CHAR_ESC))
                begin
                    mode_next = tksd_pkg::MODE_ESC;
                end
            end
            tksd_pkg::MODE_ESC:
            begin
                if (is_byte)
                begin
                    if (b == tksd_pkg::CHAR_LBRK)
                    begin
                        mode_next = tksd_pkg::MODE_CSI;
                    end
                    else if (b == tksd_pkg::CHAR_O)
                    begin
                        mode_next = tksd_pkg::MODE_SS3;
                    end
                    else if ((b != tksd_pkg::CHAR_B) && (b != tksd_pkg::CHAR_F))
                    begin
                        mode_next = tksd_pkg::MODE_SKIP;
                    end
                end
            end
            tksd_pkg::MODE_CSI:
            begin
                if (is_byte && is_digit)
                begin
                    mode_next  = tksd_pkg::MODE_DIGIT;
                    digit_next = b[3:0];
                end
            end
            tksd_pkg::MODE_DIGIT:
            begin
                if (is_byte && (b == tksd_pkg::CHAR_SEMI))
                begin
                    mode_next = tksd_pkg::MODE_MOD;
                end
            end
            tksd_pkg::MODE_MOD:
            begin
                if (is_byte)
                begin
                    mode_next = tksd_pkg::MODE_LETTER;
                    alt_next  = (b == tksd_pkg::CHAR_3);
                end
            end
            default:
            begin
                mode_next = tksd_pkg::MODE_IDLE;
            end
        endcase
    end

    // Result of the current beat.
    always_comb
    begin
        emit       = 1'b1;
        named.hit  = 1'b0;
        named.code = tksd_pkg::KEY_LEFT;
        case (mode_reg)
            tksd_pkg::MODE_IDLE:
            begin
                emit = is_byte && (b != tksd_pkg::CHAR_ESC);
            end
            tksd_pkg::MODE_ESC:
            begin
                if (is_byte)
                begin
                    if (b == tksd_pkg::CHAR_B)
                    begin
                        named.hit  = 1'b1;
                        named.code = tksd_pkg::KEY_WLEFT;
                    end
                    else if (b == tksd_pkg::CHAR_F)
                    begin
                        named.hit  = 1'b1;
                        named.code = tksd_pkg::KEY_WRIGHT;
                    end
                    else
                    begin
                        emit = 1'b0;
                    end
                end
            end
            tksd_pkg::MODE_CSI:
            begin
                if (is_byte)
                begin
                    emit  = !is_digit;
                    named = letter_key(b, 1'b0);
                end
            end
            tksd_pkg::MODE_SS3:
            begin
                if (is_byte && (b == tksd_pkg::CHAR_UH))
                begin
                    named.hit  = 1'b1;
                    named.code = tksd_pkg::KEY_HOME;
                end
                else if (is_byte && (b == tksd_pkg::CHAR_UF))
                begin
                    named.hit  = 1'b1;
                    named.code = tksd_pkg::KEY_END;
                end
            end
            tksd_pkg::MODE_DIGIT:
            begin
                if (is_byte && (b == tksd_pkg::CHAR_TILDE))
                begin
                    named = tilde_key(digit_reg);
                end
                else if (is_byte && (b == tksd_pkg::CHAR_SEMI))
                begin
                    emit = 1'b0;
                end
            end
            tksd_pkg::MODE_MOD:
            begin
                emit = !is_byte;
            end
            tksd_pkg::MODE_LETTER:
            begin
                if (is_byte)
                begin
                    named = letter_key(b, alt_reg);
                end
            end
            default:
            begin
                emit = 1'b1;
            end
        endcase
    end

    // Plain bytes pass through in idle; a named key gives its code; a failed sequence gives a lone ESC.
    always_comb
    begin
        result.emit = emit;
        if (mode_reg == tksd_pkg::MODE_IDLE)
        begin
            result.beat.special = 1'b0;
            result.beat.key     = b;
        end
        else if (named.hit)
        begin
            result.beat.special = 1'b1;
            result.beat.key     = {{(8 - tksd_pkg::KeyCodeW){1'b0}}, named.code};
        end
        else
        begin
            result.beat.special = 1'b0;
            result.beat.key     = tksd_pkg::CHAR_ESC;
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= tksd_pkg::MODE_IDLE;
            digit_reg <= 4'd0;
            alt_reg   <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            digit_reg <= digit_next;
            alt_reg   <= alt_next;
        end
    end

endmodule

// File: rtl/tksd_out_stage.sv
// Result register that holds one key beat until the receiver takes it.
module tksd_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  tksd_pkg::dec_result_t result,
    output logic                  advance,
    output logic                  key_valid,
    input  logic                  key_ready,
    output tksd_pkg::key_beat_t   key_event
);

    logic                vld_reg;
    logic                vld_next;
    tksd_pkg::key_beat_t data_reg;

    // The register can load when empty or when its beat is taken this cycle.
    assign advance = !vld_reg || key_ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (advance)
        begin
            vld_next = fire && result.emit;
        end
    end

    // Control register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (advance && fire && result.emit)
        begin
            data_reg <= result.beat;
        end
    end

    assign key_valid = vld_reg;
    assign key_event = data_reg;

endmodule

// File: rtl/terminal_key_sequence_decoder_core.sv
// Top level of the terminal key sequence decoder.
//
// The item channel carries one beat per received byte (opcode 0) or per read
// timeout (opcode 1). The key channel carries at most one key beat per item:
// a plain byte (special 0) or a named key code (special 1).
// Both channels are valid/ready; a beat moves when valid and ready are high.
// An accepted item lands in an input register, is decoded combinationally
// against the parser state, and its key beat, if any, is loaded into the
// result register as soon as that register can take it.
// Throughput is one item per cycle while the result register is not stalled;
// the parser state registers update once per item.
// Items that only advance the parser (ESC, a sequence prefix, a timeout while
// idle) produce no key beat.
// Reset empties both registers and returns the parser to idle.
// When the receiver stalls, the result register holds its beat, the next
// item waits in the input register, and item_ready drops until the result
// register frees up.
module terminal_key_sequence_decoder_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  tksd_pkg::item_t     item,
    output logic                key_valid,
    input  logic                key_ready,
    output tksd_pkg::key_beat_t key_event
);

    logic                  advance;
    logic                  stage_valid;
    tksd_pkg::item_t       stage_item;
    logic                  fire;
    tksd_pkg::dec_result_t result;

    // The staged item is decoded when the result register can take it.
    assign fire = stage_valid && advance;

    tksd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .advance    (advance),
        .stage_valid(stage_valid),
        .stage_item (stage_item)
    );

    tksd_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (stage_item),
        .result(result)
    );

    tksd_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .result   (result),
        .advance  (advance),
        .key_valid(key_valid),
        .key_ready(key_ready),
        .key_event(key_event)
    );

endmodule

// File: rtl/tksd_checker.sv
// Port-level assertions for the terminal key sequence decoder and their bind.
module tksd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input tksd_pkg::item_t     item,
    input logic                key_valid,
    input logic                key_ready,
    input tksd_pkg::key_beat_t key_event
);

    // A stalled key beat stays and keeps its payload.
    a_key_hold: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && !key_ready |=> key_valid && $stable(key_event))
        else $error("key beat dropped or changed while stalled");

    // An item offered and not taken stays offered with the same payload.
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
        else $error("item beat dropped or changed while stalled");

    // With the result register empty the block always takes an item.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !key_valid |-> item_ready)
        else $error("item_ready low while no key beat is pending");

    // A new key beat stems from an accepted item that passed through the input register.
    a_key_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(key_valid) |-> $past(item_valid && item_ready, 2))
        else $error("key beat appeared without a recent item");

    // Named keys stay within the defined code range.
    a_named_range: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && key_event.special |->
            key_event.key <= {4'd0, tksd_pkg::KEY_WRIGHT})
        else $error("named key code out of range");

endmodule

bind terminal_key_sequence_decoder_core tksd_checker u_tksd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .key_valid (key_valid),
    .key_ready (key_ready),
    .key_event (key_event)
);
